// ----- rtl/ppcl_pkg.sv -----
// shared types, constants and helper functions for the palette pixel converter
`timescale 1ns / 1ps

package ppcl_pkg;

    localparam int FRAME_PIXELS    = 12288;
    localparam int PALETTE_ENTRIES = 256;
    localparam int QUEUE_DEPTH     = 2;

    localparam int INDEX_W = 8;
    localparam int COLOR_W = 24;
    localparam int SEED_W  = 32;
    localparam int COUNT_W = 14;
    localparam int SUM_W   = 22;
    localparam int LIGHT_W = 20;

    localparam logic [31:0]        LCG_MUL   = 32'd1664525;
    localparam logic [31:0]        LCG_ADD   = 32'd1013904223;
    localparam logic [18:0]        DIV3_MUL  = 19'd349526;
    localparam logic [LIGHT_W:0]   LIGHT_MAX = 21'h0FFFFF;

    typedef enum logic [1:0] {
        MODE_WRITE = 2'd0,
        MODE_REGEN = 2'd1,
        MODE_PIXEL = 2'd2
    } mode_t;

    typedef struct packed {
        mode_t                mode;
        logic [INDEX_W-1:0]   index;
        logic [COLOR_W-1:0]   color;
        logic [SEED_W-1:0]    seed;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_LOOK,
        ST_SCALE,
        ST_EMIT
    } back_state_t;

    // sum / 48 * 16, saturated to the light width
    function automatic logic [LIGHT_W-1:0] scale_light(input logic [SUM_W-1:0] sum);
        logic [SUM_W-5:0] x;
        logic [36:0]      prod;
        logic [16:0]      q;
        logic [LIGHT_W:0] v;
        x    = sum[SUM_W-1:4];
        prod = 37'(x) * 37'(DIV3_MUL);
        q    = prod[36:20];
        v    = {q, 4'b0000};
        return (v > LIGHT_MAX) ? LIGHT_MAX[LIGHT_W-1:0] : v[LIGHT_W-1:0];
    endfunction

    function automatic logic [7:0] grey_level(input logic [31:0] g);
        return g[7:0] & g[31:24] & g[23:16];
    endfunction

endpackage

// ----- rtl/ppcl_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module ppcl_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/ppcl_front.sv -----
// input side: accepts items, drops unused modes, queues commands for the back end
`timescale 1ns / 1ps

module ppcl_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [63:0]                           s_tdata,
    input  logic [1:0]                            s_tuser,
    output ppcl_pkg::cmd_t                        cmd,
    output logic                                  cmd_valid,
    input  logic                                  cmd_pop,
    output logic [$clog2(ppcl_pkg::QUEUE_DEPTH+1)-1:0] level
);

    localparam int PTR_W = (ppcl_pkg::QUEUE_DEPTH > 1) ? $clog2(ppcl_pkg::QUEUE_DEPTH) : 1;
    localparam int LVL_W = $clog2(ppcl_pkg::QUEUE_DEPTH + 1);

    ppcl_pkg::cmd_t     entry_reg [ppcl_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [LVL_W-1:0]   level_reg;
    logic [LVL_W-1:0]   level_next;
    ppcl_pkg::cmd_t     in_cmd;
    logic               keep;
    logic               push;
    logic               pop;

    // classify: only the three defined modes enter the queue
    always_comb
    begin
        in_cmd.mode  = ppcl_pkg::mode_t'(s_tuser);
        in_cmd.index = s_tdata[7:0];
        in_cmd.color = {s_tdata[15:8], s_tdata[23:16], s_tdata[31:24]};
        in_cmd.seed  = s_tdata[63:32];
        case (s_tuser)
            ppcl_pkg::MODE_WRITE,
            ppcl_pkg::MODE_REGEN,
            ppcl_pkg::MODE_PIXEL: keep = 1'b1;
            default:              keep = 1'b0;
        endcase
    end

    assign s_tready  = (level_reg != LVL_W'(ppcl_pkg::QUEUE_DEPTH));
    assign push      = s_tvalid && s_tready && keep;
    assign cmd_valid = (level_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = entry_reg[rd_ptr_reg];
    assign level     = level_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ppcl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ppcl_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                          : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- rtl/ppcl_back.sv -----
// execution side: palette store, grey fill, lookup, frame light and result register
`timescale 1ns / 1ps

module ppcl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  ppcl_pkg::cmd_t cmd,
    input  logic           cmd_valid,
    output logic           cmd_pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [87:0]    m_tdata,
    output logic           m_tlast
);

    localparam int ADDR_W = $clog2(ppcl_pkg::PALETTE_ENTRIES);

    ppcl_pkg::back_state_t       state_reg;
    ppcl_pkg::back_state_t       state_next;

    logic [31:0]                 gen_reg;
    logic [31:0]                 gen_next;
    logic [ADDR_W-1:0]           pos_reg;
    logic [ppcl_pkg::COUNT_W-1:0] count_reg;
    logic [ppcl_pkg::SUM_W-1:0]  sum_r_reg;
    logic [ppcl_pkg::SUM_W-1:0]  sum_g_reg;
    logic [ppcl_pkg::SUM_W-1:0]  sum_b_reg;
    logic [ppcl_pkg::COLOR_W-1:0] rgb_reg;
    logic                        last_reg;
    logic                        last_next;
    logic [ppcl_pkg::LIGHT_W-1:0] light_r_reg;
    logic [ppcl_pkg::LIGHT_W-1:0] light_g_reg;
    logic [ppcl_pkg::LIGHT_W-1:0] light_b_reg;
    logic                        out_valid_reg;
    logic [87:0]                 out_data_reg;
    logic                        out_last_reg;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_waddr;
    logic [ppcl_pkg::COLOR_W-1:0] ram_wdata;
    logic [ppcl_pkg::COLOR_W-1:0] ram_rdata;
    logic                        out_free;
    logic                        out_load;
    logic [7:0]                  grey;
    logic [31:0]                 gen_prod;

    ppcl_ram #(
        .WIDTH (ppcl_pkg::COLOR_W),
        .DEPTH (ppcl_pkg::PALETTE_ENTRIES)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cmd.index),
        .rdata (ram_rdata)
    );

    assign grey      = ppcl_pkg::grey_level(gen_reg);
    assign gen_prod  = gen_reg * ppcl_pkg::LCG_MUL;
    assign gen_next  = gen_prod + ppcl_pkg::LCG_ADD;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_next = ({1'b0, count_reg} + 1'b1) >= (ppcl_pkg::COUNT_W+1)'(ppcl_pkg::FRAME_PIXELS);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppcl_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.mode)
                        ppcl_pkg::MODE_REGEN: state_next = ppcl_pkg::ST_FILL;
                        ppcl_pkg::MODE_PIXEL: state_next = ppcl_pkg::ST_LOOK;
                        default:              state_next = ppcl_pkg::ST_IDLE;
                    endcase
                end
            end
            ppcl_pkg::ST_FILL:
            begin
                if (pos_reg == ADDR_W'(ppcl_pkg::PALETTE_ENTRIES - 1))
                begin
                    state_next = ppcl_pkg::ST_IDLE;
                end
            end
            ppcl_pkg::ST_LOOK:
            begin
                state_next = last_next ? ppcl_pkg::ST_SCALE : ppcl_pkg::ST_EMIT;
            end
            ppcl_pkg::ST_SCALE:
            begin
                state_next = ppcl_pkg::ST_EMIT;
            end
            ppcl_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ppcl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppcl_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop   = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = cmd.index;
        ram_wdata = cmd.color;
        out_load  = 1'b0;
        case (state_reg)
            ppcl_pkg::ST_IDLE:
            begin
                cmd_pop = cmd_valid;
                ram_we  = cmd_valid && (cmd.mode == ppcl_pkg::MODE_WRITE);
            end
            ppcl_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = {grey, grey, grey};
            end
            ppcl_pkg::ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppcl_pkg::ST_IDLE;
            gen_reg       <= '0;
            pos_reg       <= '0;
            count_reg     <= '0;
            sum_r_reg     <= '0;
            sum_g_reg     <= '0;
            sum_b_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ppcl_pkg::ST_IDLE:
                begin
                    if (cmd_valid && (cmd.mode == ppcl_pkg::MODE_REGEN))
                    begin
                        gen_reg <= cmd.seed;
                        pos_reg <= '0;
                    end
                end
                ppcl_pkg::ST_FILL:
                begin
                    gen_reg <= gen_next;
                    pos_reg <= pos_reg + 1'b1;
                end
                ppcl_pkg::ST_LOOK:
                begin
                    sum_r_reg <= sum_r_reg + ppcl_pkg::SUM_W'(ram_rdata[23:16]);
                    sum_g_reg <= sum_g_reg + ppcl_pkg::SUM_W'(ram_rdata[15:8]);
                    sum_b_reg <= sum_b_reg + ppcl_pkg::SUM_W'(ram_rdata[7:0]);
                    count_reg <= last_next ? '0 : count_reg + 1'b1;
                end
                ppcl_pkg::ST_SCALE:
                begin
                    sum_r_reg <= '0;
                    sum_g_reg <= '0;
                    sum_b_reg <= '0;
                end
                default:
                begin
                    gen_reg <= gen_reg;
                end
            endcase
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ppcl_pkg::ST_LOOK)
        begin
            rgb_reg     <= ram_rdata;
            last_reg    <= last_next;
            light_r_reg <= '0;
            light_g_reg <= '0;
            light_b_reg <= '0;
        end
        if (state_reg == ppcl_pkg::ST_SCALE)
        begin
            light_r_reg <= ppcl_pkg::scale_light(sum_r_reg);
            light_g_reg <= ppcl_pkg::scale_light(sum_g_reg);
            light_b_reg <= ppcl_pkg::scale_light(sum_b_reg);
        end
        if (out_load)
        begin
            out_data_reg <= {4'b0000, light_b_reg, light_g_reg, light_r_reg,
                             rgb_reg[7:0], rgb_reg[15:8], rgb_reg[23:16]};
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- rtl/palette_pixel_converter_with_light_core.sv -----
// top level of the palette pixel converter with frame light measurement
`timescale 1ns / 1ps

// usage
// input stream s_*: tuser carries the mode (0 palette write, 1 grey regenerate, 2 pixel,
// 3 ignored); tdata carries index, red, green, blue and the generator seed
// output stream m_*: one item per pixel with its palette color; tlast marks the last
// pixel of a frame and then the item also carries the three scaled light sums
// a two-item command queue separates input acceptance from execution, so the input
// keeps flowing while a finished result waits on m_tready
// steps of the execution unit (one palette ram port sets the pace):
//   palette write in the idle state, regenerate one entry per cycle after the idle state,
//   pixel idle, lookup and emit, with a light scaling step before emit on the last pixel of a frame
// from pixel acceptance to m_tvalid a pixel passes the queue, these steps and the result register
// a stalled receiver holds the result register; the unit waits for it, then the
// queue fills and s_tready drops
// reset clears the queue, pixel counter, sums and generator; palette contents stay
// undefined until written

module palette_pixel_converter_with_light_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // color_index, write_red, write_green, write_blue, start_seed
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // out_red, out_green, out_blue, light_red, light_green,
                                   // light_blue, zero fill
    output logic        m_tlast
);

    ppcl_pkg::cmd_t                                cmd;
    logic                                          cmd_valid;
    logic                                          cmd_pop;
    logic [$clog2(ppcl_pkg::QUEUE_DEPTH+1)-1:0]    level;

    ppcl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .level     (level)
    );

    ppcl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= ($bits(level))'(ppcl_pkg::QUEUE_DEPTH))
        else $error("command queue over capacity");

    a_light_zero_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> (m_tdata[87:24] == '0))
        else $error("light fields nonzero before frame end");
`endif

endmodule

// ----- tb/tb_palette_pixel_converter_with_light_core.sv -----
// self-checking testbench for the palette pixel converter with frame light measurement
`timescale 1ns / 1ps

module tb_palette_pixel_converter_with_light_core;

    localparam logic [1:0] MODE_UNUSED   = 2'd3;
    localparam int         LIGHT_DIVISOR = 48;
    localparam int         LIGHT_SCALE   = 16;
    localparam int         LIGHT_CEIL    = 20'hFFFFF;
    localparam int         STALL_LIMIT   = 4000;
    localparam int         DRAIN_CYCLES  = 300;
    localparam int         RANDOM_ITEMS  = 575;
    localparam int         FINAL_ITEMS   = 100;
    localparam int         MAX_REPORTS   = 10;

    typedef struct packed {
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic                         last;
        logic [ppcl_pkg::LIGHT_W-1:0] light_r;
        logic [ppcl_pkg::LIGHT_W-1:0] light_g;
        logic [ppcl_pkg::LIGHT_W-1:0] light_b;
    } pixel_out_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [31:0] seed;
        logic        typed;
        pixel_out_t  want;
    } stim_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;   // color_index, write_red, write_green, write_blue, start_seed
    logic [1:0]  s_tuser = '0;   // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;        // out_red, out_green, out_blue, light_red, light_green,
                                 // light_blue, zero fill
    logic        m_tlast;

    palette_pixel_converter_with_light_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // palette state mirrored from accepted items
    logic [ppcl_pkg::COLOR_W-1:0] palette_copy [ppcl_pkg::PALETTE_ENTRIES];
    logic [ppcl_pkg::COUNT_W-1:0] frame_count;
    logic [ppcl_pkg::SUM_W-1:0]   red_total;
    logic [ppcl_pkg::SUM_W-1:0]   green_total;
    logic [ppcl_pkg::SUM_W-1:0]   blue_total;

    pixel_out_t expected_pixels [$];

    bit bursts_on = 1'b1;
    int mismatches = 0;
    int pixels_checked = 0;
    int frames_seen = 0;
    int writes_sent = 0;
    int regens_sent = 0;
    int items_sent = 0;
    int quiet_cycles = 0;
    int stall_left = 0;

    function automatic logic [ppcl_pkg::LIGHT_W-1:0] scaled_light(
        input logic [ppcl_pkg::SUM_W-1:0] total);
        int unsigned v;
        v = (int'(total) / LIGHT_DIVISOR) * LIGHT_SCALE;
        return (v > LIGHT_CEIL) ? LIGHT_CEIL[ppcl_pkg::LIGHT_W-1:0]
                                : v[ppcl_pkg::LIGHT_W-1:0];
    endfunction

    function automatic stim_t row(input logic [1:0] mode, input logic [7:0] index,
                                  input logic [7:0] red, input logic [7:0] green,
                                  input logic [7:0] blue, input logic [31:0] seed,
                                  input logic typed = 1'b0, input logic [23:0] rgb = '0);
        stim_t it;
        it = '0;
        it.mode = mode;
        it.index = index;
        it.red = red;
        it.green = green;
        it.blue = blue;
        it.seed = seed;
        it.typed = typed;
        it.want.red = rgb[23:16];
        it.want.green = rgb[15:8];
        it.want.blue = rgb[7:0];
        return it;
    endfunction

    function automatic stim_t random_item();
        int pick;
        logic [1:0] mode;
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            mode = ppcl_pkg::MODE_WRITE;
        end
        else if (pick < 30)
        begin
            mode = ppcl_pkg::MODE_REGEN;
        end
        else if (pick < 38)
        begin
            mode = MODE_UNUSED;
        end
        else
        begin
            mode = ppcl_pkg::MODE_PIXEL;
        end
        return row(mode, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   32'($urandom));
    endfunction

    // updates the mirrored state and returns the pixel result, if any
    task automatic compute_pixel_result(input stim_t it, output bit has_out,
                                        output pixel_out_t res);
        logic [31:0] g;
        logic [7:0]  grey;
        logic [23:0] entry;
        has_out = 1'b0;
        res = '0;
        if (it.mode == ppcl_pkg::MODE_WRITE)
        begin
            palette_copy[it.index] = {it.red, it.green, it.blue};
        end
        else if (it.mode == ppcl_pkg::MODE_REGEN)
        begin
            g = it.seed;
            for (int i = 0; i < ppcl_pkg::PALETTE_ENTRIES; i++)
            begin
                grey = g[7:0] & g[31:24] & g[23:16];
                palette_copy[i] = {grey, grey, grey};
                g = g * ppcl_pkg::LCG_MUL + ppcl_pkg::LCG_ADD;
            end
        end
        else if (it.mode == ppcl_pkg::MODE_PIXEL)
        begin
            entry = palette_copy[it.index];
            has_out = 1'b1;
            res.red = entry[23:16];
            res.green = entry[15:8];
            res.blue = entry[7:0];
            red_total = red_total + ppcl_pkg::SUM_W'(entry[23:16]);
            green_total = green_total + ppcl_pkg::SUM_W'(entry[15:8]);
            blue_total = blue_total + ppcl_pkg::SUM_W'(entry[7:0]);
            if (int'(frame_count) + 1 >= ppcl_pkg::FRAME_PIXELS)
            begin
                res.last = 1'b1;
                res.light_r = scaled_light(red_total);
                res.light_g = scaled_light(green_total);
                res.light_b = scaled_light(blue_total);
                red_total = '0;
                green_total = '0;
                blue_total = '0;
                frame_count = '0;
            end
            else
            begin
                frame_count = frame_count + 1'b1;
            end
        end
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input stim_t it);
        bit         has_out;
        pixel_out_t res;
        if (bursts_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= it.mode;
        s_tdata <= {it.seed, it.blue, it.green, it.red, it.index};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        compute_pixel_result(it, has_out, res);
        if (has_out)
        begin
            expected_pixels.push_back(it.typed ? it.want : res);
        end
        items_sent++;
        if (it.mode == ppcl_pkg::MODE_WRITE)
        begin
            writes_sent++;
        end
        if (it.mode == ppcl_pkg::MODE_REGEN)
        begin
            regens_sent++;
        end
        @(negedge clk);
    endtask

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (bursts_on && $urandom_range(0, 4) == 0)
        begin
            stall_left = $urandom_range(1, 4) - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        pixel_out_t got;
        pixel_out_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.red = m_tdata[7:0];
            got.green = m_tdata[15:8];
            got.blue = m_tdata[23:16];
            got.last = m_tlast;
            got.light_r = m_tdata[43:24];
            got.light_g = m_tdata[63:44];
            got.light_b = m_tdata[83:64];
            if (expected_pixels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected item: rgb %h %h %h last %b light %h %h %h",
                             got.red, got.green, got.blue, got.last,
                             got.light_r, got.light_g, got.light_b);
                end
            end
            else
            begin
                want = expected_pixels.pop_front();
                pixels_checked++;
                if (got.last)
                begin
                    frames_seen++;
                end
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.last !== want.last ||
                    got.light_r !== want.light_r || got.light_g !== want.light_g ||
                    got.light_b !== want.light_b)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("pixel %0d: expected rgb %h %h %h last %b light %h %h %h",
                                 pixels_checked, want.red, want.green, want.blue,
                                 want.last, want.light_r, want.light_g, want.light_b);
                        $display("pixel %0d: actual   rgb %h %h %h last %b light %h %h %h",
                                 pixels_checked, got.red, got.green, got.blue,
                                 got.last, got.light_r, got.light_g, got.light_b);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    stim_t directed_rows [$];

    initial
    begin
        directed_rows = '{
            row(ppcl_pkg::MODE_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h0),
            row(ppcl_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'h000000),
            row(ppcl_pkg::MODE_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF, 1'b1,
                24'hFFFFFF),
            row(ppcl_pkg::MODE_WRITE, 8'h55, 8'hAA, 8'h55, 8'h0F, 32'h55555555),
            row(ppcl_pkg::MODE_PIXEL, 8'h55, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'hAA550F),
            row(ppcl_pkg::MODE_WRITE, 8'hAA, 8'h55, 8'hAA, 8'hF0, 32'hAAAAAAAA),
            row(ppcl_pkg::MODE_PIXEL, 8'hAA, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'h55AAF0),
            row(MODE_UNUSED, 8'h00, 8'hFF, 8'hFF, 8'hFF, 32'hFFFFFFFF),
            row(ppcl_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'h000000),
            row(MODE_UNUSED, 8'hFF, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'hFFFFFF),
            row(ppcl_pkg::MODE_REGEN, 8'h00, 8'h00, 8'h00, 8'h00, 32'hFFFFFFFF),
            row(ppcl_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'hFFFFFF),
            row(ppcl_pkg::MODE_PIXEL, 8'h01, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_REGEN, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 32'h00000000),
            row(ppcl_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'h000000),
            row(ppcl_pkg::MODE_PIXEL, 8'h01, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_PIXEL, 8'h80, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_REGEN, 8'h00, 8'h00, 8'h00, 8'h00, 32'h12345678),
            row(ppcl_pkg::MODE_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_PIXEL, 8'hFF, 8'h00, 8'h00, 8'h00, 32'h0),
            row(ppcl_pkg::MODE_WRITE, 8'h07, 8'hFF, 8'h00, 8'hFF, 32'h0),
            row(ppcl_pkg::MODE_PIXEL, 8'h07, 8'h00, 8'h00, 8'h00, 32'h0, 1'b1, 24'hFF00FF)
        };

        frame_count = '0;
        red_total = '0;
        green_total = '0;
        blue_total = '0;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i]);
        end

        // every entry has been filled by now, so any index may be read
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            send_item(random_item());
        end

        // last part at full rate with random content
        bursts_on = 1'b0;
        send_item(row(ppcl_pkg::MODE_REGEN, 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 32'($urandom)));
        for (int i = 1; i < FINAL_ITEMS; i++)
        begin
            send_item(random_item());
        end
        s_tvalid <= 1'b0;

        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        mismatches += expected_pixels.size();
        $display("sent %0d items: %0d palette writes, %0d grey regenerations",
                 items_sent, writes_sent, regens_sent);
        $display("checked %0d pixel results across %0d completed frames",
                 pixels_checked, frames_seen);
        if (mismatches == 0)
        begin
            $display("end of test: clean");
        end
        else
        begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/ppcl_pkg.sv
rtl/ppcl_ram.sv
rtl/ppcl_front.sv
rtl/ppcl_back.sv
rtl/palette_pixel_converter_with_light_core.sv
tb/tb_palette_pixel_converter_with_light_core.sv
